// ----- hw/rtl/phss_pkg.sv -----
package phss_pkg;

   // Shape of one display run
   localparam int unsigned CODE_BITS  = 8;
   localparam int unsigned DIGITS     = 3;
   localparam int unsigned RUN_BITS   = CODE_BITS * DIGITS;
   localparam int unsigned CNT_W      = $clog2(RUN_BITS);
   localparam int unsigned PEAK_W     = 8;
   localparam int unsigned QUEUE_SIZE = 2;

   // Digit slots on the result stream
   localparam logic [1:0] DIGIT_HUNDREDS = 2'd0;
   localparam logic [1:0] DIGIT_TENS     = 2'd1;
   localparam logic [1:0] DIGIT_ONES     = 2'd2;

   // Common-cathode codes, bit 0 = segment a ... bit 6 = segment g
   localparam logic [7:0] SEG_0 = 8'h3f;
   localparam logic [7:0] SEG_1 = 8'h06;
   localparam logic [7:0] SEG_2 = 8'h5b;
   localparam logic [7:0] SEG_3 = 8'h4f;
   localparam logic [7:0] SEG_4 = 8'h66;
   localparam logic [7:0] SEG_5 = 8'h6d;
   localparam logic [7:0] SEG_6 = 8'h7d;
   localparam logic [7:0] SEG_7 = 8'h07;
   localparam logic [7:0] SEG_8 = 8'h7f;
   localparam logic [7:0] SEG_9 = 8'h6f;

   // Front end sequencer
   typedef enum logic [1:0] {
      F_IDLE,
      F_SCAN,
      F_DRAIN,
      F_PUSH
   } front_state_type;

   // Back end sequencer
   typedef enum logic {
      B_IDLE,
      B_SHIFT
   } back_state_type;

   // One peak handed across the queue
   typedef struct packed {
      logic              valid;
      logic [PEAK_W-1:0] peak;
   } peak_xfer_type;

   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = SEG_0;
         4'd1:    code = SEG_1;
         4'd2:    code = SEG_2;
         4'd3:    code = SEG_3;
         4'd4:    code = SEG_4;
         4'd5:    code = SEG_5;
         4'd6:    code = SEG_6;
         4'd7:    code = SEG_7;
         4'd8:    code = SEG_8;
         4'd9:    code = SEG_9;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   // Peak to three segment codes, hundreds in the top byte.
   // Tens digit via x*205 >> 11, exact for x below 100.
   function automatic logic [RUN_BITS-1:0] seg_word(input logic [PEAK_W-1:0] peak);
      logic [1:0]  hund;
      logic [6:0]  rem;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [3:0]  ones;
      logic [6:0]  tens_x10;
      if (peak >= 8'd200) begin
         hund = 2'd2;
         rem  = 7'(peak - 8'd200);
      end else if (peak >= 8'd100) begin
         hund = 2'd1;
         rem  = 7'(peak - 8'd100);
      end else begin
         hund = 2'd0;
         rem  = 7'(peak);
      end
      prod     = 15'(rem) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = 7'(tens) * 7'd10;
      ones     = 4'(rem - tens_x10);
      return {seg_code({2'b00, hund}), seg_code(tens), seg_code(ones)};
   endfunction

endpackage

// ----- hw/rtl/phss_ram.sv -----
module phss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 30
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/phss_front.sv -----
module phss_front
   import phss_pkg::*;
#(
   parameter int SAMPLES = 30
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [4:0]    sample_index,
   input  logic [7:0]    sample_value,
   input  logic          queue_full,
   output peak_xfer_type push
);

   localparam int AW = $clog2(SAMPLES);

   front_state_type state_ff, state_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic              rd_live_ff, rd_live_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [PEAK_W-1:0] max_ff, max_in;
   logic [SAMPLES-1:0] valid_ff, valid_in;

   logic              accept;
   logic              scan_step;
   logic              in_range;
   logic [6:0]        idx_ext;
   logic [AW-1:0]     wr_addr;
   logic [PEAK_W-1:0] rd_data;
   logic [PEAK_W-1:0] rd_value;
   logic              last_addr;

   // Request classification
   assign idx_ext   = 7'(sample_index);
   assign in_range  = idx_ext < 7'(SAMPLES);
   assign wr_addr   = idx_ext[AW-1:0];
   assign accept    = req_valid && req_ready;
   assign last_addr = cnt_ff == AW'(SAMPLES - 1);

   phss_ram #(
      .WIDTH (PEAK_W),
      .DEPTH (SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && in_range),
      .wr_addr (wr_addr),
      .wr_data (sample_value),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   // Never-written slots read as zero
   assign rd_value = rd_ok_ff ? rd_data : '0;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (req_valid) state_in = F_SCAN;
         F_SCAN:  if (last_addr) state_in = F_DRAIN;
         F_DRAIN: state_in = F_PUSH;
         F_PUSH:  if (!queue_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_ready  = 1'b0;
      scan_step  = 1'b0;
      push.valid = 1'b0;
      push.peak  = max_ff;
      case (state_ff)
         F_IDLE:  req_ready  = 1'b1;
         F_SCAN:  scan_step  = 1'b1;
         F_DRAIN: ;
         F_PUSH:  push.valid = !queue_full;
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      cnt_in     = cnt_ff;
      rd_live_in = scan_step;
      rd_ok_in   = valid_ff[cnt_ff];
      max_in     = max_ff;
      valid_in   = valid_ff;
      if (accept) begin
         cnt_in = '0;
         max_in = '0;
         if (in_range) begin
            valid_in[wr_addr] = 1'b1;
         end
      end else begin
         if (scan_step) begin
            cnt_in = cnt_ff + AW'(1);
         end
         if (rd_live_ff && (rd_value > max_ff)) begin
            max_in = rd_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         rd_live_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         rd_live_ff <= rd_live_in;
         valid_ff   <= valid_in;
      end
      cnt_ff   <= cnt_in;
      rd_ok_ff <= rd_ok_in;
      max_ff   <= max_in;
   end

endmodule

// ----- hw/rtl/phss_queue.sv -----
module phss_queue
   import phss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  peak_xfer_type push,
   output logic          full,
   output peak_xfer_type head,
   input  logic          pop
);

   localparam int PW = $clog2(QUEUE_SIZE);
   localparam int CW = $clog2(QUEUE_SIZE + 1);

   logic [PEAK_W-1:0] mem_ff [QUEUE_SIZE];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              do_pop;

   assign full       = cnt_ff == CW'(QUEUE_SIZE);
   assign head.valid = cnt_ff != '0;
   assign head.peak  = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_SIZE - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_SIZE - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push.valid && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (!push.valid && do_pop) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.peak;
      end
   end

`ifndef ASSERT_OFF
   // Occupancy never passes the queue size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(QUEUE_SIZE))
      else $error("queue occupancy overflow");

   // A push into a full queue would lose a peak
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push.valid)
      else $error("push while queue full");

   // A pop from an empty queue would repeat a peak
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) && !push.valid |=> cnt_ff == '0)
      else $error("queue count moved without a push");
`endif

endmodule

// ----- hw/rtl/phss_back.sv -----
module phss_back
   import phss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  peak_xfer_type head,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    digit_position,
   output logic          segment_bit,
   output logic          digit_done,
   output logic          last
);

   back_state_type state_ff, state_in;
   logic [RUN_BITS-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                out_valid_ff, out_valid_in;
   logic [1:0]          out_pos_ff, out_pos_in;
   logic                out_bit_ff, out_bit_in;
   logic                out_done_ff, out_done_in;
   logic                out_last_ff, out_last_in;

   logic emit;
   logic run_end;

   assign run_end = cnt_ff == CNT_W'(RUN_BITS - 1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  if (head.valid) state_in = B_SHIFT;
         B_SHIFT: if (emit && run_end) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      pop  = 1'b0;
      emit = 1'b0;
      case (state_ff)
         B_IDLE:  pop  = head.valid;
         B_SHIFT: emit = !out_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // Shift register and output stage
   always_comb begin
      shift_in     = shift_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_pos_in   = out_pos_ff;
      out_bit_in   = out_bit_ff;
      out_done_in  = out_done_ff;
      out_last_in  = out_last_ff;
      if (pop) begin
         shift_in = seg_word(head.peak);
         cnt_in   = '0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_pos_in   = cnt_ff[CNT_W-1:3];
         out_bit_in   = shift_ff[RUN_BITS-1];
         out_done_in  = cnt_ff[2:0] == 3'(CODE_BITS - 1);
         out_last_in  = run_end;
         shift_in     = {shift_ff[RUN_BITS-2:0], 1'b0};
         cnt_in       = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      shift_ff    <= shift_in;
      cnt_ff      <= cnt_in;
      out_pos_ff  <= out_pos_in;
      out_bit_ff  <= out_bit_in;
      out_done_ff <= out_done_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign digit_position = out_pos_ff;
   assign segment_bit    = out_bit_ff;
   assign digit_done     = out_done_ff;
   assign last           = out_last_ff;

`ifndef ASSERT_OFF
   // A popped peak starts a fresh run at bit zero
   a_load: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == B_SHIFT) && (cnt_ff == '0))
      else $error("run did not start at bit zero");

   // The final bit of a run is the eighth bit of the ones digit
   a_last_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last |-> digit_done && (digit_position == DIGIT_ONES))
      else $error("run ended off the ones digit");

   // No new peak is taken while a run is still shifting
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_SHIFT) |-> !pop)
      else $error("pop during a run");
`endif

endmodule

// ----- hw/rtl/peak_hold_seven_segment_serializer_core.sv -----
// Peak-hold seven-segment serializer. Each request writes an 8-bit sample into
// one of SAMPLES slots (an index at or past SAMPLES writes nothing); the block
// then finds the largest stored value and sends its hundreds, tens and ones
// digits as common-cathode segment codes, 24 responses of one bit each, MSB
// first, digit by digit. The front end takes a request, writes it, scans the
// store through the RAM's registered read port at one slot per cycle and
// queues the peak; it takes no new request until that peak is queued. The
// back end loads a peak while idle, then shifts one bit per cycle while the
// sink is ready and takes no new peak until the run is out; a two-entry peak
// queue lets the front run ahead of a stalled response side.
// Slots read as zero until written; there is no clearing pass after reset.
module peak_hold_seven_segment_serializer_core
   import phss_pkg::*;
#(
   parameter int SAMPLES = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // sample_index[4:0], sample_value[12:5], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // segment_bit[0], zero pad
   output logic [2:0]  rsp_tuser,  // digit_position[1:0], digit_done[2]
   output logic        rsp_tlast
);

   peak_xfer_type push;
   peak_xfer_type head;
   logic          queue_full;
   logic          pop;
   logic [1:0]    digit_position;
   logic          segment_bit;
   logic          digit_done;

   phss_front #(
      .SAMPLES (SAMPLES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .sample_index (req_tdata[4:0]),
      .sample_value (req_tdata[12:5]),
      .queue_full   (queue_full),
      .push         (push)
   );

   phss_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   phss_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .digit_position (digit_position),
      .segment_bit    (segment_bit),
      .digit_done     (digit_done),
      .last           (rsp_tlast)
   );

   assign rsp_tdata = {7'b0, segment_bit};
   assign rsp_tuser = {digit_done, digit_position};

endmodule
